/* rtl/path_snap_segment_extractor_macros.svh */
// Assertion helpers used by the top-level extractor to check its own logic.
`ifndef PATH_SNAP_SEGMENT_EXTRACTOR_MACROS_SVH
`define PATH_SNAP_SEGMENT_EXTRACTOR_MACROS_SVH

// Condition in one cycle implies a result in the next, outside reset.
`define PSE_ASSERT_NEXT(lbl, cond, res) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (res)) \
        else $error("pse check failed");

// Same, but also checked while reset is applied.
`define PSE_ASSERT_NEXT_ALWAYS(lbl, cond, res) \
    lbl: assert property (@(posedge i_clk) (cond) |=> (res)) \
        else $error("pse reset check failed");

`endif

/* rtl/pse_pkg.sv */
`timescale 1ns / 1ps
package pse_pkg;

    // Input beat
    typedef struct packed {
        logic               is_move;
        logic               closes;
        logic signed [31:0] raw_x;
        logic signed [31:0] raw_y;
        logic               path_end;
    } t_in;

    // Result beat
    typedef struct packed {
        logic               shape_kind;
        logic signed [31:0] p0_x;
        logic signed [31:0] p0_y;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic [30:0]        radius;
        logic               last_of_run;
    } t_out;

    typedef struct packed {
        logic signed [31:0] mat_a;
        logic signed [31:0] mat_b;
        logic signed [31:0] mat_c;
        logic signed [31:0] mat_d;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic               lines_enable;
        logic               circles_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_pt;

    // Classified segment handed from the front to the back
    typedef struct packed {
        logic is_move;
        logic closes;
        logic path_end;
        t_pt  pt;
    } t_item;

    localparam logic [2:0] CFG_MAT_A    = 3'd0;
    localparam logic [2:0] CFG_MAT_B    = 3'd1;
    localparam logic [2:0] CFG_MAT_C    = 3'd2;
    localparam logic [2:0] CFG_MAT_D    = 3'd3;
    localparam logic [2:0] CFG_OFFSET_X = 3'd4;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [2:0] CFG_LINES_EN = 3'd6;
    localparam logic [2:0] CFG_CIRC_EN  = 3'd7;

    localparam logic SHAPE_LINE   = 1'b0;
    localparam logic SHAPE_CIRCLE = 1'b1;

    localparam int          MAX_RESULTS = 32;
    localparam int          NRES_W      = 6;
    localparam logic [31:0] ONE_Q16     = 32'd65536;

endpackage

/* rtl/path_snap_segment_extractor.sv */
`timescale 1ns / 1ps
// Path snap segment extractor.
// Input channel: one path segment per beat (i_in_valid / o_in_stall), carrying
// move and close flags, a raw Q16.16 point and an end-of-path mark.
// Output channel: line or circle results (o_out_valid / i_out_stall); the
// last result caused by one segment carries last_of_run.
// Configuration: write i_cfg_wdata to register i_cfg_idx with i_cfg_we,
// only while the block is idle.
// Mapping: the front maps each point on one shared 32x32 multiplier and
// stalls the input until that point is in the queue, so it takes no new
// segment while one is still being mapped.
// A flush to lines reads each stored point in turn and waits on the output.
// A circle test sums the points for the centroid, runs three bit-serial
// divisions and takes a 64-bit bit-serial square root for each point.
// A two-entry queue lets the front map new points while the back flushes.
// Reset clears the queue, the subpath state and the registers to their
// defaults; the point store needs no clearing.
// A stalled receiver holds the current result; one more result is held
// internally before the back sequencer waits.
module path_snap_segment_extractor
    import pse_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  t_in         i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out        o_out_data,
    input  logic        i_out_stall
);
    `include "path_snap_segment_extractor_macros.svh"

    t_cfg  r_cfg;
    logic  push;
    t_item push_data;
    logic  full;
    logic  pop;
    t_item pop_data;
    logic  empty;
    logic  lines_wr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mat_a          <= 32'sd65536;
            r_cfg.mat_b          <= '0;
            r_cfg.mat_c          <= '0;
            r_cfg.mat_d          <= 32'sd65536;
            r_cfg.offset_x       <= '0;
            r_cfg.offset_y       <= '0;
            r_cfg.lines_enable   <= 1'b1;
            r_cfg.circles_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAT_A:    r_cfg.mat_a          <= i_cfg_wdata;
                CFG_MAT_B:    r_cfg.mat_b          <= i_cfg_wdata;
                CFG_MAT_C:    r_cfg.mat_c          <= i_cfg_wdata;
                CFG_MAT_D:    r_cfg.mat_d          <= i_cfg_wdata;
                CFG_OFFSET_X: r_cfg.offset_x       <= i_cfg_wdata;
                CFG_OFFSET_Y: r_cfg.offset_y       <= i_cfg_wdata;
                CFG_LINES_EN: r_cfg.lines_enable   <= i_cfg_wdata[0];
                CFG_CIRC_EN:  r_cfg.circles_enable <= i_cfg_wdata[0];
            endcase
        end
    end

    assign lines_wr = i_cfg_we && (i_cfg_idx == CFG_LINES_EN);

    pse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    pse_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    pse_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lines_en  (r_cfg.lines_enable),
        .i_circ_en   (r_cfg.circles_enable),
        .i_empty     (empty),
        .i_item      (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Front takes one beat and then works on it
    `PSE_ASSERT_NEXT(a_front_busy, i_in_valid && !o_in_stall, o_in_stall)
    // Enable write lands in the register
    `PSE_ASSERT_NEXT(a_cfg_lines, lines_wr, r_cfg.lines_enable == $past(i_cfg_wdata[0]))
    // No result right after reset
    `PSE_ASSERT_NEXT_ALWAYS(a_rst_out, !i_rst_n, !o_out_valid)

endmodule

/* rtl/pse_div.sv */
`timescale 1ns / 1ps
module pse_div
    import pse_pkg::*;
#(
    parameter int DW = 40,
    parameter int VW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quot;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;
    logic [VW:0]     rem_sh;
    logic [VW:0]     rem_sub;
    logic            q_bit;

    // One quotient bit per cycle, restoring
    always_comb begin
        rem_sh  = {r_rem, r_quot[DW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        q_bit   = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[DW-2:0], q_bit};
                r_rem  <= q_bit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* rtl/pse_isqrt.sv */
`timescale 1ns / 1ps
module pse_isqrt
    import pse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    // Two radicand bits per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

/* rtl/pse_fifo.sv */
`timescale 1ns / 1ps
module pse_fifo
    import pse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_pop_data,
    output logic  o_empty
);
    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        do_push;
    logic        do_pop;

    assign o_full     = (r_cnt == 2'd2);
    assign o_empty    = (r_cnt == 2'd0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rp];

    // Two-entry queue between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_push_data;
                r_wp        <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

/* rtl/pse_front.sv */
`timescale 1ns / 1ps
module pse_front
    import pse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    input  t_in   i_in_data,
    output logic  o_in_stall,
    output logic  o_push,
    output t_item o_push_data,
    input  logic  i_full
);
    typedef enum logic [2:0] {
        FS_AX, FS_CY, FS_BX, FS_DY, FS_Y, FS_PUSH
    } t_fstep;

    logic               r_busy;
    t_fstep             r_step;
    logic               r_mv;
    logic               r_cl;
    logic               r_pe;
    logic signed [31:0] r_rx;
    logic signed [31:0] r_ry;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] off;
    logic signed [64:0] tot;
    logic signed [49:0] tsum;
    logic signed [31:0] coord;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] s);
        if (s[49:31] == '0 || s[49:31] == '1) begin
            return s[31:0];
        end
        return s[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // Pick the coefficient pair for this step
    always_comb begin
        mul_a = i_cfg.mat_a;
        mul_b = r_rx;
        off   = i_cfg.offset_x;
        unique case (r_step)
            FS_AX:   begin mul_a = i_cfg.mat_a; mul_b = r_rx; end
            FS_CY:   begin mul_a = i_cfg.mat_c; mul_b = r_ry; end
            FS_BX:   begin mul_a = i_cfg.mat_b; mul_b = r_rx; off = i_cfg.offset_x; end
            FS_DY:   begin mul_a = i_cfg.mat_d; mul_b = r_ry; end
            FS_Y:    begin off = i_cfg.offset_y; end
            FS_PUSH: begin off = i_cfg.offset_y; end
            default: begin off = i_cfg.offset_x; end
        endcase
        tot   = {r_acc[63], r_acc} + {r_prod[63], r_prod};
        tsum  = {tot[64], tot[64:16]} + {{18{off[31]}}, off};
        coord = sat32(tsum);
    end

    // Sequence the four products through one multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= FS_AX;
        end else if (!r_busy) begin
            if (i_in_valid) begin
                r_busy <= 1'b1;
                r_step <= FS_AX;
                r_mv   <= i_in_data.is_move;
                r_cl   <= i_in_data.closes;
                r_pe   <= i_in_data.path_end;
                r_rx   <= i_in_data.raw_x;
                r_ry   <= i_in_data.raw_y;
            end
        end else begin
            unique case (r_step)
                FS_AX: begin
                    r_prod <= mul_a * mul_b;
                    r_step <= FS_CY;
                end
                FS_CY: begin
                    r_acc  <= r_prod;
                    r_prod <= mul_a * mul_b;
                    r_step <= FS_BX;
                end
                FS_BX: begin
                    r_px   <= coord;
                    r_prod <= mul_a * mul_b;
                    r_step <= FS_DY;
                end
                FS_DY: begin
                    r_acc  <= r_prod;
                    r_prod <= mul_a * mul_b;
                    r_step <= FS_Y;
                end
                FS_Y: begin
                    r_py   <= coord;
                    r_step <= FS_PUSH;
                end
                FS_PUSH: begin
                    if (!i_full) begin
                        r_busy <= 1'b0;
                        r_step <= FS_AX;
                    end
                end
                default: r_step <= FS_AX;
            endcase
        end
    end

    assign o_in_stall           = r_busy;
    assign o_push               = r_busy && (r_step == FS_PUSH);
    assign o_push_data.is_move  = r_mv;
    assign o_push_data.closes   = r_cl;
    assign o_push_data.path_end = r_pe;
    assign o_push_data.pt.x     = r_px;
    assign o_push_data.pt.y     = r_py;

endmodule

/* rtl/pse_back.sv */
`timescale 1ns / 1ps
module pse_back
    import pse_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_lines_en,
    input  logic  i_circ_en,
    input  logic  i_empty,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_out_valid,
    output t_out  o_out_data,
    input  logic  i_out_stall
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int SW = CW + 34;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MV, ST_CL, ST_PE, ST_PE_DONE, ST_FIN, ST_FL,
        ST_SUM_RD, ST_SUM_ACC, ST_DIVX, ST_DIVX_W, ST_DIVY, ST_DIVY_W,
        ST_D_RD, ST_D_DX, ST_D_SQX, ST_D_SQY, ST_D_ROOT, ST_D_ROOT_W,
        ST_MEAN, ST_MEAN_W, ST_JUDGE, ST_CIRC_EMIT,
        ST_LN_FIRST_RD, ST_LN_FIRST, ST_LN_RD, ST_LN_EMIT, ST_LN_CLOSE
    } t_state;

    typedef enum logic [1:0] { RET_MV, RET_CL, RET_PE } t_ret;

    t_state             r_state;
    t_ret               r_ret;
    logic               r_closed;
    t_item              r_item;
    logic [CW-1:0]      r_count;
    t_pt                r_move;
    logic               r_open;
    logic [CW-1:0]      r_idx;
    t_pt                r_mem [MAX_POINTS];
    t_pt                r_rdata;
    logic signed [SW-1:0] r_sx;
    logic signed [SW-1:0] r_sy;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic [31:0]        r_ax;
    logic [31:0]        r_ay;
    logic [63:0]        r_sq;
    logic [63:0]        r_sq2;
    logic [SW-1:0]      r_sumr;
    logic [31:0]        r_maxr;
    logic [31:0]        r_minr;
    logic [SW-1:0]      r_mean;
    t_pt                r_first;
    t_pt                r_prev;
    logic [NRES_W-1:0]  r_nres;
    logic               r_hold_v;
    t_out               r_hold;
    logic               r_out_v;
    t_out               r_out;

    logic               div_start;
    logic [SW-1:0]      div_dvd;
    logic               div_done;
    logic [SW-1:0]      div_quot;
    logic [CW-1:0]      div_rem;
    logic signed [SW-1:0] fdiv;
    logic               sqrt_start;
    logic [63:0]        sqrt_in;
    logic [64:0]        sq_sum;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               emit_req;
    logic               emit_skip;
    logic               emit_ok;
    logic               emit_go;
    logic               emit_done;
    t_out               emit_data;
    logic               out_free;
    logic               mem_we;
    logic [IW-1:0]      mem_addr;
    t_pt                mem_wdata;
    logic               last_idx;
    logic               is_circle;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [33:0]        spread;

    function automatic t_state ret_next(input t_ret r);
        unique case (r)
            RET_MV:  return ST_MV;
            RET_CL:  return ST_CL;
            RET_PE:  return ST_PE_DONE;
            default: return ST_FIN;
        endcase
    endfunction

    pse_div #(.DW(SW), .VW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pse_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sqrt_in),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Divider and root operands
    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_sumr;
        if (r_state == ST_DIVX) begin
            div_start = 1'b1;
            div_dvd   = r_sx[SW-1] ? SW'(-r_sx) : SW'(r_sx);
        end else if (r_state == ST_DIVY) begin
            div_start = 1'b1;
            div_dvd   = r_sy[SW-1] ? SW'(-r_sy) : SW'(r_sy);
        end else if (r_state == ST_MEAN) begin
            div_start = 1'b1;
        end
        // floor division: round the magnitude up for a negative sum
        if (r_state == ST_DIVX_W ? r_sx[SW-1] : r_sy[SW-1]) begin
            fdiv = -$signed(div_quot + SW'(div_rem != '0));
        end else begin
            fdiv = $signed(div_quot);
        end
        sq_sum     = {1'b0, r_sq} + {1'b0, r_sq2};
        sqrt_in    = sq_sum[64] ? '1 : sq_sum[63:0];
        sqrt_start = (r_state == ST_D_ROOT);
        dx         = {r_rdata.x[31], r_rdata.x} - {r_cx[31], r_cx};
        dy         = {r_rdata.y[31], r_rdata.y} - {r_cy[31], r_cy};
        spread     = {r_maxr - r_minr, 2'b00};
        is_circle  = (r_mean >= SW'(ONE_Q16)) &&
                     ({{(SW-34){1'b0}}, spread} <= r_mean);
        last_idx   = ((r_idx + CW'(1)) == r_count);
    end

    // Result candidates
    always_comb begin
        emit_req            = 1'b0;
        emit_data.shape_kind  = SHAPE_LINE;
        emit_data.p0_x        = r_prev.x;
        emit_data.p0_y        = r_prev.y;
        emit_data.p1_x        = r_rdata.x;
        emit_data.p1_y        = r_rdata.y;
        emit_data.radius      = '0;
        emit_data.last_of_run = 1'b0;
        if (r_state == ST_CIRC_EMIT) begin
            emit_req             = 1'b1;
            emit_data.shape_kind = SHAPE_CIRCLE;
            emit_data.p0_x       = r_cx;
            emit_data.p0_y       = r_cy;
            emit_data.p1_x       = '0;
            emit_data.p1_y       = '0;
            emit_data.radius     = (r_mean[SW-1:31] != '0) ? 31'h7FFF_FFFF : r_mean[30:0];
        end else if (r_state == ST_LN_EMIT) begin
            emit_req = 1'b1;
        end else if (r_state == ST_LN_CLOSE) begin
            emit_req       = 1'b1;
            emit_data.p1_x = r_first.x;
            emit_data.p1_y = r_first.y;
        end
        out_free  = !r_out_v || !i_out_stall;
        emit_ok   = !r_hold_v || out_free;
        emit_skip = (r_nres >= NRES_W'(MAX_RESULTS));
        emit_go   = emit_req && !emit_skip && emit_ok;
        emit_done = emit_req && (emit_skip || emit_ok);
    end

    // Point store writes
    always_comb begin
        o_pop     = (r_state == ST_IDLE) && !i_empty;
        mem_we    = 1'b0;
        mem_addr  = r_count[IW-1:0];
        mem_wdata = i_item.pt;
        if (o_pop && !i_item.is_move && (r_count < CW'(MAX_POINTS))) begin
            mem_we = 1'b1;
        end else if (r_state == ST_MV) begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = r_item.pt;
        end else if (r_state == ST_CL) begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = r_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_idx[IW-1:0]];
    end

    // Segment sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= RET_PE;
            r_count  <= '0;
            r_move   <= '0;
            r_open   <= 1'b0;
            r_nres   <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (emit_go) begin
                if (r_hold_v) begin
                    r_out   <= r_hold;
                    r_out_v <= 1'b1;
                end
                r_hold   <= emit_data;
                r_hold_v <= 1'b1;
                r_nres   <= r_nres + 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_item;
                        r_nres <= '0;
                        if (i_item.is_move) begin
                            r_closed <= 1'b0;
                            r_ret    <= RET_MV;
                            r_state  <= ST_FL;
                        end else begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                r_count <= r_count + 1'b1;
                            end
                            if (i_item.closes) begin
                                r_closed <= 1'b1;
                                r_ret    <= RET_CL;
                                r_state  <= ST_FL;
                            end else begin
                                r_state <= ST_PE;
                            end
                        end
                    end
                end
                ST_MV: begin
                    r_count <= CW'(1);
                    r_move  <= r_item.pt;
                    r_open  <= 1'b1;
                    r_state <= ST_PE;
                end
                ST_CL: begin
                    r_count <= CW'(1);
                    r_state <= ST_PE;
                end
                ST_PE: begin
                    if (r_item.path_end) begin
                        r_closed <= 1'b0;
                        r_ret    <= RET_PE;
                        r_state  <= ST_FL;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_PE_DONE: begin
                    r_count <= '0;
                    r_move  <= '0;
                    r_open  <= 1'b0;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_hold_v) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out             <= r_hold;
                        r_out.last_of_run <= 1'b1;
                        r_out_v           <= 1'b1;
                        r_hold_v          <= 1'b0;
                        r_state           <= ST_IDLE;
                    end
                end
                ST_FL: begin
                    r_idx <= '0;
                    priority if (!r_open) begin
                        r_state <= ret_next(r_ret);
                    end else if (i_circ_en && r_closed && r_count >= CW'(3)) begin
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sumr  <= '0;
                        r_maxr  <= '0;
                        r_minr  <= '1;
                        r_state <= ST_SUM_RD;
                    end else if (i_lines_en && r_count >= CW'(2)) begin
                        r_state <= ST_LN_FIRST_RD;
                    end else begin
                        r_state <= ret_next(r_ret);
                    end
                end
                // centroid sums
                ST_SUM_RD: r_state <= ST_SUM_ACC;
                ST_SUM_ACC: begin
                    r_sx  <= r_sx + {{(SW-32){r_rdata.x[31]}}, r_rdata.x};
                    r_sy  <= r_sy + {{(SW-32){r_rdata.y[31]}}, r_rdata.y};
                    r_idx <= r_idx + 1'b1;
                    r_state <= last_idx ? ST_DIVX : ST_SUM_RD;
                end
                ST_DIVX: r_state <= ST_DIVX_W;
                ST_DIVX_W: begin
                    if (div_done) begin
                        r_cx    <= fdiv[31:0];
                        r_state <= ST_DIVY;
                    end
                end
                ST_DIVY: r_state <= ST_DIVY_W;
                ST_DIVY_W: begin
                    if (div_done) begin
                        r_cy    <= fdiv[31:0];
                        r_idx   <= '0;
                        r_state <= ST_D_RD;
                    end
                end
                // distance of each point to the centroid
                ST_D_RD: r_state <= ST_D_DX;
                ST_D_DX: begin
                    r_ax    <= dx[32] ? 32'(-dx) : dx[31:0];
                    r_ay    <= dy[32] ? 32'(-dy) : dy[31:0];
                    r_state <= ST_D_SQX;
                end
                ST_D_SQX: begin
                    r_sq    <= r_ax * r_ax;
                    r_state <= ST_D_SQY;
                end
                ST_D_SQY: begin
                    r_sq2   <= r_ay * r_ay;
                    r_state <= ST_D_ROOT;
                end
                ST_D_ROOT: r_state <= ST_D_ROOT_W;
                ST_D_ROOT_W: begin
                    if (sqrt_done) begin
                        r_sumr <= r_sumr + SW'(sqrt_root);
                        if (sqrt_root > r_maxr) begin
                            r_maxr <= sqrt_root;
                        end
                        if (sqrt_root < r_minr) begin
                            r_minr <= sqrt_root;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= last_idx ? ST_MEAN : ST_D_RD;
                    end
                end
                ST_MEAN: r_state <= ST_MEAN_W;
                ST_MEAN_W: begin
                    if (div_done) begin
                        r_mean  <= div_quot;
                        r_state <= ST_JUDGE;
                    end
                end
                ST_JUDGE: begin
                    r_idx <= '0;
                    priority if (is_circle) begin
                        r_state <= ST_CIRC_EMIT;
                    end else if (i_lines_en && r_count >= CW'(2)) begin
                        r_state <= ST_LN_FIRST_RD;
                    end else begin
                        r_state <= ret_next(r_ret);
                    end
                end
                ST_CIRC_EMIT: begin
                    if (emit_done) begin
                        r_state <= ret_next(r_ret);
                    end
                end
                // line segments between stored points
                ST_LN_FIRST_RD: r_state <= ST_LN_FIRST;
                ST_LN_FIRST: begin
                    r_first <= r_rdata;
                    r_prev  <= r_rdata;
                    r_idx   <= CW'(1);
                    r_state <= ST_LN_RD;
                end
                ST_LN_RD: r_state <= ST_LN_EMIT;
                ST_LN_EMIT: begin
                    if (emit_done) begin
                        r_prev <= r_rdata;
                        r_idx  <= r_idx + 1'b1;
                        if (last_idx) begin
                            r_state <= r_closed ? ST_LN_CLOSE : ret_next(r_ret);
                        end else begin
                            r_state <= ST_LN_RD;
                        end
                    end
                end
                ST_LN_CLOSE: begin
                    if (emit_done) begin
                        r_state <= ret_next(r_ret);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

/* dv/path_snap_segment_extractor_tb.sv */
`timescale 1ns / 1ps
module path_snap_segment_extractor_tb;
    import pse_pkg::*;

    localparam int NPTS = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    t_in         i_in_data;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out_data;
    logic        i_out_stall;

    path_snap_segment_extractor #(.MAX_POINTS(NPTS)) dut (.*);

    // Predictor copy of the registers and the subpath state
    t_cfg cfg_m;
    t_pt  pts_m [NPTS];
    int   npts_m;
    t_pt  move_m;
    bit   open_m;
    int   run_m;

    t_in  seg_q[$];
    t_out shape_q[$];
    int   errors, seg_sent, shapes_seen, circles_seen;
    int   max_gap;
    bit   hold_req, hold_done;
    int   hold_cnt;
    int   in_gap, out_wait;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Q16.16 matrix row: exact products, floored sum, offset, saturate
    function automatic logic signed [31:0] map_row(logic signed [31:0] k1,
            logic signed [31:0] k2, logic signed [31:0] off,
            logic signed [31:0] x, logic signed [31:0] y);
        longint p1, p2, q1, q2, r1, r2, s;
        p1 = longint'(k1) * longint'(x);
        p2 = longint'(k2) * longint'(y);
        q1 = p1 >>> 16;
        q2 = p2 >>> 16;
        r1 = p1 - q1 * 65536;
        r2 = p2 - q2 * 65536;
        s = q1 + q2 + ((r1 + r2) >>> 16) + longint'(off);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint div_floor(longint s, longint n);
        longint q;
        q = s / n;
        if (s - q * n < 0) q = q - 1;
        return q;
    endfunction

    // Centroid, distance spread and mean radius of the stored points
    function automatic bit is_round(int n, output longint cx, output longint cy,
                                    output logic [30:0] rad);
        longint sx, sy, dx, dy;
        logic [63:0] ax, ay, sq, sq2, d, sumr, maxr, minr, mean;
        logic [64:0] t;
        sx = 0;
        sy = 0;
        sumr = 0;
        maxr = 0;
        minr = '1;
        for (int i = 0; i < n; i++) begin
            sx += longint'(pts_m[i].x);
            sy += longint'(pts_m[i].y);
        end
        cx = div_floor(sx, n);
        cy = div_floor(sy, n);
        for (int i = 0; i < n; i++) begin
            dx = longint'(pts_m[i].x) - cx;
            dy = longint'(pts_m[i].y) - cy;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            sq = ax * ax;
            sq2 = ay * ay;
            t = {1'b0, sq} + {1'b0, sq2};
            sq = t[64] ? '1 : t[63:0];
            d = root64(sq);
            sumr += d;
            if (d > maxr) maxr = d;
            if (d < minr) minr = d;
        end
        mean = sumr / n;
        rad = mean > 64'h7FFFFFFF ? 31'h7FFFFFFF : mean[30:0];
        if (mean < 64'(ONE_Q16)) return 1'b0;
        return 4 * (maxr - minr) <= mean;
    endfunction

    function automatic void push_shape(int unsigned kind, longint x0, longint y0,
                                       longint x1, longint y1, logic [30:0] rad);
        t_out r;
        if (run_m >= MAX_RESULTS) return;
        r.shape_kind = kind[0];
        r.p0_x = x0[31:0];
        r.p0_y = y0[31:0];
        r.p1_x = x1[31:0];
        r.p1_y = y1[31:0];
        r.radius = rad;
        r.last_of_run = 1'b0;
        shape_q = {shape_q, r};
        run_m++;
    endfunction

    // Emit a subpath as a circle or as its edges
    function automatic void flush_subpath(bit closed);
        longint cx, cy;
        logic [30:0] rad;
        int n;
        n = npts_m;
        if (!open_m) return;
        if (cfg_m.circles_enable && closed && n >= 3) begin
            if (is_round(n, cx, cy, rad)) begin
                push_shape(SHAPE_CIRCLE, cx, cy, 0, 0, rad);
                return;
            end
        end
        if (cfg_m.lines_enable && n >= 2) begin
            for (int i = 0; i + 1 < n; i++)
                push_shape(SHAPE_LINE, pts_m[i].x, pts_m[i].y,
                           pts_m[i+1].x, pts_m[i+1].y, 0);
            if (closed)
                push_shape(SHAPE_LINE, pts_m[n-1].x, pts_m[n-1].y,
                           pts_m[0].x, pts_m[0].y, 0);
        end
    endfunction

    function automatic void store_pt(t_pt p);
        if (npts_m < NPTS) begin
            pts_m[npts_m] = p;
            npts_m++;
        end
    endfunction

    // Expected shapes for one accepted segment
    function automatic void predict_segment(t_in s);
        t_pt p;
        run_m = 0;
        p.x = map_row(cfg_m.mat_a, cfg_m.mat_c, cfg_m.offset_x, s.raw_x, s.raw_y);
        p.y = map_row(cfg_m.mat_b, cfg_m.mat_d, cfg_m.offset_y, s.raw_x, s.raw_y);
        if (s.is_move) begin
            flush_subpath(1'b0);
            npts_m = 0;
            store_pt(p);
            move_m = p;
            open_m = 1'b1;
        end else begin
            store_pt(p);
            if (s.closes) begin
                flush_subpath(1'b1);
                npts_m = 0;
                store_pt(move_m);
            end
        end
        if (s.path_end) begin
            flush_subpath(1'b0);
            npts_m = 0;
            move_m = '0;
            open_m = 1'b0;
        end
        if (run_m > 0) shape_q[shape_q.size()-1].last_of_run = 1'b1;
    endfunction

    // Driver: offer queued segments with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_segment(i_in_data);
                seg_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (seg_q.size() > 0) begin
                    i_in_data  <= seg_q.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap     <= $urandom_range(0, max_gap);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Count down the one long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= 300;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: check each accepted shape against the oldest expectation
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait    <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                shapes_seen++;
                if (shape_q.size() == 0) begin
                    $error("unexpected shape beat %p", o_out_data);
                    errors++;
                end else begin
                    e = shape_q.pop_front();
                    if (o_out_data.shape_kind == SHAPE_CIRCLE) circles_seen++;
                    if (o_out_data.shape_kind !== e.shape_kind) begin
                        $error("shape_kind exp %0d got %0d", e.shape_kind,
                               o_out_data.shape_kind);
                        errors++;
                    end
                    if (o_out_data.p0_x !== e.p0_x) begin
                        $error("p0_x exp %0d got %0d", e.p0_x, o_out_data.p0_x);
                        errors++;
                    end
                    if (o_out_data.p0_y !== e.p0_y) begin
                        $error("p0_y exp %0d got %0d", e.p0_y, o_out_data.p0_y);
                        errors++;
                    end
                    if (o_out_data.p1_x !== e.p1_x) begin
                        $error("p1_x exp %0d got %0d", e.p1_x, o_out_data.p1_x);
                        errors++;
                    end
                    if (o_out_data.p1_y !== e.p1_y) begin
                        $error("p1_y exp %0d got %0d", e.p1_y, o_out_data.p1_y);
                        errors++;
                    end
                    if (o_out_data.radius !== e.radius) begin
                        $error("radius exp %0d got %0d", e.radius, o_out_data.radius);
                        errors++;
                    end
                    if (o_out_data.last_of_run !== e.last_of_run) begin
                        $error("last_of_run exp %0d got %0d", e.last_of_run,
                               o_out_data.last_of_run);
                        errors++;
                    end
                end
            end
            // Hold off during the long stretch, else a random wait per beat
            if (hold_cnt > 0) begin
                i_out_stall <= 1'b1;
            end else if (out_wait > 0) begin
                out_wait    <= out_wait - 1;
                i_out_stall <= (out_wait > 1);
            end else if (o_out_valid && !i_out_stall) begin
                out_wait    <= $urandom_range(0, max_gap);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in seg(bit mv, bit cl, logic [31:0] x, logic [31:0] y, bit pe);
        t_in s;
        s.is_move = mv;
        s.closes = cl;
        s.raw_x = x;
        s.raw_y = y;
        s.path_end = pe;
        return s;
    endfunction

    function automatic void add_seg(t_in s);
        seg_q = {seg_q, s};
    endfunction

    function automatic logic [31:0] near_coord();
        return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MAT_A:    cfg_m.mat_a = val;
            CFG_MAT_B:    cfg_m.mat_b = val;
            CFG_MAT_C:    cfg_m.mat_c = val;
            CFG_MAT_D:    cfg_m.mat_d = val;
            CFG_OFFSET_X: cfg_m.offset_x = val;
            CFG_OFFSET_Y: cfg_m.offset_y = val;
            CFG_LINES_EN: cfg_m.lines_enable = val[0];
            default:      cfg_m.circles_enable = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d, logic [31:0] e, logic [31:0] f,
                               bit len, bit cen);
        write_reg(CFG_MAT_A, a);
        write_reg(CFG_MAT_B, b);
        write_reg(CFG_MAT_C, c);
        write_reg(CFG_MAT_D, d);
        write_reg(CFG_OFFSET_X, e);
        write_reg(CFG_OFFSET_Y, f);
        write_reg(CFG_LINES_EN, {31'd0, len});
        write_reg(CFG_CIRC_EN, {31'd0, cen});
    endtask

    // Drain everything, then let a full circle test worth of cycles pass
    task automatic drain();
        while (seg_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (shape_q.size() > 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    // Points on a circle, the last one closing the subpath
    task automatic queue_circle(int cx, int cy, int r, int n, bit pe);
        real ang;
        for (int i = 0; i < n; i++) begin
            ang = 6.283185307 * i / n;
            add_seg(seg(i == 0, i == n - 1, cx + int'(r * $cos(ang)),
                        cy + int'(r * $sin(ang)), pe && i == n - 1));
        end
    endtask

    // Mostly well-formed subpaths, some circles, some noise
    task automatic queue_random(int budget);
        int added, k, sel;
        bit cl;
        added = 0;
        while (added < budget) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                                : $urandom_range(1, 6);
                // keep the group within the budget
                if (added + k + 1 > budget)
                    k = (budget - added > 2) ? budget - added - 1 : 1;
                add_seg(seg(1'b1, $urandom_range(0, 1), near_coord(),
                            near_coord(), 1'b0));
                cl = $urandom_range(0, 1);
                for (int i = 0; i < k; i++)
                    add_seg(seg(1'b0, cl && i == k - 1, near_coord(),
                                near_coord(),
                                i == k - 1 && $urandom_range(0, 2) == 0));
                added += k + 1;
            end else if (sel < 8) begin
                k = $urandom_range(3, 12);
                if (added + k > budget)
                    k = (budget - added > 3) ? budget - added : 3;
                queue_circle(int'(near_coord()), int'(near_coord()),
                             $urandom_range(32'h1_0000, 32'h20_0000), k,
                             $urandom_range(0, 1));
                added += k;
            end else begin
                add_seg(seg($urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom, $urandom, $urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        errors = 0; seg_sent = 0; shapes_seen = 0; circles_seen = 0;
        max_gap = 6; hold_req = 0;
        cfg_m = '0;
        cfg_m.mat_a = ONE_Q16; cfg_m.mat_d = ONE_Q16;
        cfg_m.lines_enable = 1'b1; cfg_m.circles_enable = 1'b1;
        npts_m = 0; move_m = '0; open_m = 1'b0; run_m = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: segments before any move, close in that state
        add_seg(seg(0, 0, 32'h0001_0000, 32'h0002_0000, 0));
        add_seg(seg(0, 1, 32'h0003_0000, 32'h0001_0000, 0));
        add_seg(seg(0, 0, 32'h0005_0000, 32'h0005_0000, 1));
        // Open polyline ended by a move, then a closed square
        add_seg(seg(1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        add_seg(seg(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        add_seg(seg(1, 0, 0, 0, 0));
        add_seg(seg(0, 0, 32'h000A_0000, 0, 0));
        add_seg(seg(0, 0, 32'h000A_0000, 32'h000A_0000, 0));
        add_seg(seg(0, 1, 0, 32'h000A_0000, 0));
        // Subpath continues from the move point after the close, path end
        add_seg(seg(0, 0, 32'hFFF0_0000, 32'hFFF0_0000, 1));
        // Circle, and a tiny circle below unit radius
        queue_circle(0, 0, 32'h000A_0000, 8, 0);
        queue_circle(32'h0010_0000, 0, 32'h0000_8000, 6, 1);
        drain();

        // Full store overflow on a closed subpath, gaps off and a long hold-off
        max_gap = 0;
        load_matrix(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 1, 1);
        hold_req = 1'b1;
        add_seg(seg(1, 0, 0, 0, 0));
        for (int i = 1; i < 36; i++)
            add_seg(seg(0, i == 35, i << 16, (i * i) << 12, i == 35));
        queue_random(8);
        drain();
        max_gap = 6;

        // Rotation, scale and offsets
        load_matrix(32'h0000_B505, 32'h0000_B505, 32'hFFFF_4AFB, 32'h0000_B505,
                    32'h0123_4567, 32'hFEDC_BA98, 1, 1);
        queue_random(8);
        drain();

        // Extreme coefficients and offsets: saturating transform
        load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
        queue_random(7);
        drain();

        // Circles only, lines only, neither
        load_matrix(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 1);
        queue_random(7);
        drain();
        load_matrix(32'h0002_0000, 0, 0, 32'h0002_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 1, 0);
        queue_random(7);
        drain();
        load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0);
        queue_random(5);
        drain();

        // Random matrix, both enabled
        load_matrix($urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                    $urandom_range(0, 32'h0000_8000),
                    $urandom_range(0, 32'h0000_8000),
                    $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                    $urandom, $urandom, 1, 1);
        queue_random(8);
        drain();

        $display("segments sent: %0d, shapes checked: %0d (%0d circles)",
                 seg_sent, shapes_seen, circles_seen);
        $display("covered: saturating matrices, store overflow, enables, hold-off");
        if (errors == 0) begin
            $display("path_snap_segment_extractor_tb passed");
        end else begin
            $display("path_snap_segment_extractor_tb failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20ms;
        $display("path_snap_segment_extractor_tb failed");
        $finish;
    end

endmodule
